@@ design/lcts_pkg.sv @@
`timescale 1ns / 1ps
// package for the load cell tare and scale block
// shared types and constants; no dependencies

package lcts_pkg;

  localparam logic [25:0] MG_Q16 = 26'd65536000;
  localparam logic [51:0] SCALE_RESET = 52'd27525120;
  localparam logic [15:0] DEADBAND_RESET = 16'd200;

  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_TARE    = 2'd1,
    OP_CAL     = 2'd2,
    OP_SETSC   = 2'd3
  } op_t;

  // one classified request queued between front and back
  typedef struct packed {
    op_t                op;
    logic               last;
    logic signed [23:0] sample;
    logic [23:0]        known;
    logic signed [51:0] new_scale;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

endpackage

@@ design/lcts_front.sv @@
`timescale 1ns / 1ps
// front part: accepts input items, picks the sample and queues a request
// depends on lcts_pkg

module lcts_front #(
  parameter int RAW_BITS = 24,
  parameter int DEPTH    = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic                in_sample_ready,
  input  logic [23:0]         in_raw_code,
  input  logic                in_last_sample,
  input  logic [23:0]         in_known_weight_mg,
  input  logic signed [51:0]  in_scale_value,
  input  logic signed [23:0]  last_raw,
  output logic                q_valid,
  output lcts_pkg::req_t      q_req,
  input  logic                q_take
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lcts_pkg::req_t      mem [DEPTH];
  logic [AW-1:0]       wp_r, rp_r;
  logic [AW:0]         cnt_r;
  logic                push;
  lcts_pkg::req_t      req;
  logic signed [23:0]  code;

  // sign-extend the low RAW_BITS of the converter word
  assign code = 24'($signed(in_raw_code[RAW_BITS-1:0]));

  // classify; a timed-out sample takes the back part's last_raw
  always_comb begin
    req.op        = lcts_pkg::op_t'(in_operation);
    req.last      = in_last_sample;
    req.sample    = in_sample_ready ? code : last_raw;
    req.known     = in_known_weight_mg;
    req.new_scale = in_scale_value;
  end

  assign in_stall = (cnt_r != (AW+1)'(0));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != (AW+1)'(0));
  assign q_req    = mem[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= req;
  end

  // queue pointers; one request in flight so last_raw is settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (q_take) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_take);
    end
  end

endmodule

@@ design/lcts_div.sv @@
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle, truncates toward zero
// depends on lcts_pkg

module lcts_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [51:0] num,
  input  logic signed [51:0] den,
  output logic               done,
  output logic signed [51:0] quot
);

  logic [51:0] q_r, r_r, d_r;
  logic [5:0]  n_r;
  logic        neg_r, busy_r, done_r;
  logic [52:0] trial;

  assign trial = {r_r, q_r[51]} - {1'b0, d_r};
  assign done  = done_r;
  assign quot  = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      n_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= 6'd52;
      end else if (busy_r) begin
        n_r <= n_r - 6'd1;
        if (n_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitudes, shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[51] ? 52'(-num) : 52'(num);
      d_r   <= den[51] ? 52'(-den) : 52'(den);
      r_r   <= '0;
      neg_r <= num[51] ^ den[51];
    end else if (busy_r) begin
      if (!trial[52]) begin
        r_r <= trial[51:0];
        q_r <= {q_r[50:0], 1'b1};
      end else begin
        r_r <= {r_r[50:0], q_r[51]};
        q_r <= {q_r[50:0], 1'b0};
      end
    end
  end

endmodule

@@ design/lcts_back.sv @@
`timescale 1ns / 1ps
// back part: state registers, batch handling, scaling and result register
// depends on lcts_pkg and lcts_div

module lcts_back #(
  parameter int MAX_BATCH = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        deadband,
  input  logic               q_valid,
  input  lcts_pkg::req_t     q_req,
  output logic               q_take,
  output logic signed [23:0] last_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [51:0] out_weight_mg,
  output logic signed [23:0] out_raw_value,
  output logic signed [23:0] out_zero_offset,
  output logic signed [51:0] out_scale_q16,
  output logic               out_batch_applied
);

  lcts_pkg::state_t   st_r, st_nxt;
  lcts_pkg::req_t     rq_r;
  logic signed [23:0] last_raw_r, offset_r, used_r;
  logic signed [51:0] scale_r, weight_r;
  logic signed [31:0] sum_r;
  logic [7:0]         bcnt_r;
  logic               applied_r, ovalid_r;
  logic               is_div_w_r;   // a division is pending for this request
  logic signed [51:0] den_r, prod_r;
  logic signed [51:0] mul_w, num_w;
  logic               div_start, div_done;
  logic signed [51:0] quot;
  logic signed [51:0] mag;

  // average uses the same divider
  logic               avg_mode_r;

  // net times 65536000; the net fits in 25 bits
  assign mul_w = 52'($signed(prod_r[24:0])) * 52'($signed({1'b0, lcts_pkg::MG_Q16}));
  assign num_w = avg_mode_r ? prod_r : mul_w;

  lcts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(num_w), .den(den_r), .done(div_done), .quot(quot)
  );

  assign last_raw          = last_raw_r;
  assign out_valid         = ovalid_r;
  assign out_weight_mg     = weight_r;
  assign out_raw_value     = used_r;
  assign out_zero_offset   = offset_r;
  assign out_scale_q16     = scale_r;
  assign out_batch_applied = applied_r;
  assign mag = quot[51] ? -quot : quot;

  // next state
  always_comb begin
    st_nxt    = st_r;
    q_take    = 1'b0;
    div_start = 1'b0;
    case (st_r)
      lcts_pkg::ST_IDLE: if (q_valid && !ovalid_r) begin
        q_take = 1'b1;
        st_nxt = lcts_pkg::ST_MUL;
      end
      lcts_pkg::ST_MUL: begin
        if (is_div_w_r) begin
          div_start = 1'b1;
          st_nxt    = lcts_pkg::ST_DIV;
        end else begin
          st_nxt = lcts_pkg::ST_FIX;
        end
      end
      lcts_pkg::ST_DIV: if (div_done) st_nxt = lcts_pkg::ST_FIX;
      // calibrate goes round again for the scale division
      lcts_pkg::ST_FIX: begin
        if (is_div_w_r && avg_mode_r && rq_r.op == lcts_pkg::OP_CAL) begin
          st_nxt = lcts_pkg::ST_MUL;
        end else begin
          st_nxt = lcts_pkg::ST_OUT;
        end
      end
      lcts_pkg::ST_OUT: st_nxt = lcts_pkg::ST_IDLE;
      default: st_nxt = lcts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= lcts_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0;
      offset_r   <= '0;
      scale_r    <= lcts_pkg::SCALE_RESET;
      weight_r   <= '0;
      sum_r      <= '0;
      bcnt_r     <= '0;
      ovalid_r   <= 1'b0;
      applied_r  <= 1'b0;
      is_div_w_r <= 1'b0;
      avg_mode_r <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (st_r)
        // take request, do the cheap parts, set up the first division
        lcts_pkg::ST_IDLE: if (q_take) begin
          rq_r       <= q_req;
          applied_r  <= 1'b0;
          is_div_w_r <= 1'b0;
          avg_mode_r <= 1'b0;
          used_r     <= last_raw_r;
          case (q_req.op)
            lcts_pkg::OP_MEASURE: begin
              last_raw_r <= q_req.sample;
              used_r     <= q_req.sample;
              prod_r     <= 52'(q_req.sample) - 52'(offset_r);
              den_r      <= scale_r;
              is_div_w_r <= (scale_r != '0);
            end
            lcts_pkg::OP_TARE, lcts_pkg::OP_CAL: begin
              if (q_req.op == lcts_pkg::OP_TARE || q_req.known != '0) begin
                logic signed [31:0] s;
                logic [7:0]         c;
                s = sum_r;
                c = bcnt_r;
                used_r <= q_req.sample;
                if (q_req.sample != '0 && c < 8'(MAX_BATCH)) begin
                  s = s + 32'(q_req.sample);
                  c = c + 8'd1;
                end
                if (q_req.last) begin
                  sum_r  <= '0;
                  bcnt_r <= '0;
                  if (c != '0) begin
                    applied_r  <= 1'b1;
                    avg_mode_r <= 1'b1;
                    is_div_w_r <= 1'b1;
                    prod_r     <= 52'(s);
                    den_r      <= 52'(c);
                  end
                end else begin
                  sum_r  <= s;
                  bcnt_r <= c;
                end
              end else if (q_req.last) begin
                sum_r  <= '0;
                bcnt_r <= '0;
              end
            end
            default: if (q_req.new_scale != '0) scale_r <= q_req.new_scale;
          endcase
        end
        // apply the quotient; calibrate needs a second division
        lcts_pkg::ST_FIX: if (is_div_w_r) begin
          if (avg_mode_r) begin
            if (rq_r.op == lcts_pkg::OP_TARE) begin
              offset_r   <= quot[23:0];
              weight_r   <= '0;
              is_div_w_r <= 1'b0;
            end else begin
              avg_mode_r <= 1'b0;
              prod_r     <= 52'($signed(quot[23:0])) - 52'(offset_r);
              den_r      <= 52'(rq_r.known);
            end
          end else if (rq_r.op == lcts_pkg::OP_MEASURE) begin
            weight_r   <= (mag < 52'(deadband)) ? '0 : quot;
            is_div_w_r <= 1'b0;
          end else begin
            scale_r    <= quot;
            is_div_w_r <= 1'b0;
          end
        end
        lcts_pkg::ST_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ design/load_cell_tare_and_scale.sv @@
`timescale 1ns / 1ps
// top level of the load cell tare and scale block
// depends on lcts_pkg, lcts_front, lcts_back, lcts_div

// Converts 24-bit load-cell words to milligrams with tare and calibration.
// One item at a time: a measure with a nonzero scale or a tare close with
// samples goes once through the shared 52-step serial divider, a calibrate
// close twice (average, then scale), other items not at all.
// The divider sets the rate. One result is produced per item and held in an
// output register until taken; one further request can wait in the queue.

module load_cell_tare_and_scale #(
  parameter int MAX_BATCH = 255,
  parameter int RAW_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_deadband_mg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic               in_sample_ready,
  input  logic [23:0]        in_raw_code,
  input  logic               in_last_sample,
  input  logic [23:0]        in_known_weight_mg,
  input  logic signed [51:0] in_scale_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [51:0] out_weight_mg,
  output logic signed [23:0] out_raw_value,
  output logic signed [23:0] out_zero_offset,
  output logic signed [51:0] out_scale_q16,
  output logic               out_batch_applied
);

  logic [15:0]        deadband_r;
  logic               q_valid, q_take;
  lcts_pkg::req_t     q_req;
  logic signed [23:0] last_raw;

  assign cfg_ready = 1'b1;

  // deadband register
  always_ff @(posedge clk) begin
    if (!rst_n) deadband_r <= lcts_pkg::DEADBAND_RESET;
    else if (cfg_valid) deadband_r <= cfg_deadband_mg;
  end

  lcts_front #(.RAW_BITS(RAW_BITS), .DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_sample_ready(in_sample_ready),
    .in_raw_code(in_raw_code), .in_last_sample(in_last_sample),
    .in_known_weight_mg(in_known_weight_mg), .in_scale_value(in_scale_value),
    .last_raw(last_raw),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
  );

  lcts_back #(.MAX_BATCH(MAX_BATCH)) u_back (
    .clk(clk), .rst_n(rst_n), .deadband(deadband_r),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
    .last_raw(last_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_weight_mg(out_weight_mg), .out_raw_value(out_raw_value),
    .out_zero_offset(out_zero_offset), .out_scale_q16(out_scale_q16),
    .out_batch_applied(out_batch_applied)
  );

endmodule

@@ verif/load_cell_tare_and_scale_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the load cell tare and scale block
// depends on lcts_pkg and load_cell_tare_and_scale

module load_cell_tare_and_scale_tb;

  localparam int MAX_LOAD = 255;
  localparam longint MG_PER_Q16 = 64'sd65536000;

  typedef struct {
    logic signed [51:0] weight;
    logic signed [23:0] raw;
    logic signed [23:0] offset;
    logic signed [51:0] scale;
    logic               applied;
  } weigh_result_t;

  int err_count = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // scale behavior model with a queue of pending results
  class scale_board;
    longint last_raw, offset, scale, weight, sum;
    int count;
    longint deadband;
    weigh_result_t pending[$];

    function void init();
      last_raw = 0; offset = 0; scale = 27525120; weight = 0;
      sum = 0; count = 0; deadband = 200;
      pending.delete();
    endfunction

    function void note_request(lcts_pkg::op_t op, bit ready, logic [23:0] code, bit last,
                               logic [23:0] known, logic signed [51:0] nscale);
      longint sample, used, net, w, mag, avg, kw;
      bit applied;
      weigh_result_t r;
      sample = ready ? longint'($signed(code)) : last_raw;
      used = last_raw;
      applied = 0;
      kw = longint'(known);
      if (op == lcts_pkg::OP_MEASURE) begin
        last_raw = sample;
        used = sample;
        net = sample - offset;
        if (scale != 0) begin
          w = (net * MG_PER_Q16) / scale;
          mag = w < 0 ? -w : w;
          if (mag < deadband) w = 0;
          weight = w;
        end
      end else if (op == lcts_pkg::OP_TARE || (op == lcts_pkg::OP_CAL && kw != 0)) begin
        used = sample;
        if (sample != 0 && count < MAX_LOAD) begin
          sum += sample;
          count++;
        end
        if (last) begin
          if (count > 0) begin
            avg = sum / count;
            if (op == lcts_pkg::OP_TARE) begin
              offset = avg;
              weight = 0;
            end else begin
              scale = ((avg - offset) * MG_PER_Q16) / kw;
            end
            applied = 1;
          end
          sum = 0; count = 0;
        end
      end else if (op == lcts_pkg::OP_CAL) begin
        if (last) begin
          sum = 0; count = 0;
        end
      end else if (nscale != 0) begin
        scale = longint'(nscale);
      end
      r.weight = weight[51:0];
      r.raw = used[23:0];
      r.offset = offset[23:0];
      r.scale = scale[51:0];
      r.applied = applied;
      pending.push_back(r);
    endfunction

    task check_result(weigh_result_t got);
      weigh_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.weight !== want.weight) report("weight_mg", got.weight, want.weight);
      if (got.raw !== want.raw) report("raw_value", got.raw, want.raw);
      if (got.offset !== want.offset) report("zero_offset", got.offset, want.offset);
      if (got.scale !== want.scale) report("scale_q16", got.scale, want.scale);
      if (got.applied !== want.applied)
        report("batch_applied", got.applied, want.applied);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_deadband_mg = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic in_sample_ready = 0;
  logic [23:0] in_raw_code = '0;
  logic in_last_sample = 0;
  logic [23:0] in_known_weight_mg = '0;
  logic signed [51:0] in_scale_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [51:0] out_weight_mg;
  logic signed [23:0] out_raw_value, out_zero_offset;
  logic signed [51:0] out_scale_q16;
  logic out_batch_applied;

  load_cell_tare_and_scale u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  scale_board board = new();
  int send_idle = 0, recv_idle = 0;
  longint cycles = 0;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("load_cell_tare_and_scale_tb failed");
      $finish;
    end
  end

  // receiver: random stall and result check
  always @(posedge clk) begin
    weigh_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.weight = out_weight_mg;
      got.raw = out_raw_value;
      got.offset = out_zero_offset;
      got.scale = out_scale_q16;
      got.applied = out_batch_applied;
      board.check_result(got);
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // valid stays high between back to back requests
  task automatic send(lcts_pkg::op_t op, bit ready, logic [23:0] code, bit last,
                      logic [23:0] known, logic signed [51:0] nscale);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_sample_ready <= ready;
    in_raw_code <= code;
    in_last_sample <= last;
    in_known_weight_mg <= known;
    in_scale_value <= nscale;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, ready, code, last, known, nscale);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // deadband write while idle
  task automatic write_deadband(logic [15:0] v);
    drain();
    cfg_valid <= 1;
    cfg_deadband_mg <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    board.deadband = v;
  endtask

  function automatic logic signed [51:0] rand_scale();
    case ($urandom_range(3))
      0: return $signed(52'($urandom_range(200000, 1000)) << 8);
      1: return -$signed(52'($urandom_range(30000000, 1)));
      2: return $signed(52'({$urandom, $urandom}));
      default: return 52'sd27525120;
    endcase
  endfunction

  // one random request or a batch of up to five, mostly well-formed batches
  task automatic random_request();
    int k, n;
    lcts_pkg::op_t op;
    k = $urandom_range(99);
    if (k < 45) begin
      send(lcts_pkg::OP_MEASURE, $urandom_range(9) != 0, 24'($urandom), 1'b0,
           24'($urandom), 52'($urandom));
    end else if (k < 80) begin
      op = ($urandom_range(1) == 0) ? lcts_pkg::OP_TARE : lcts_pkg::OP_CAL;
      n = $urandom_range(5, 1);
      for (int i = 0; i < n; i++)
        send(($urandom_range(9) == 0) ? lcts_pkg::OP_TARE : op, $urandom_range(9) != 0,
             ($urandom_range(7) == 0) ? 24'd0 : 24'($urandom),
             i == n - 1, ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(
             16777215, 1)), 52'($urandom));
    end else if (k < 90) begin
      send(lcts_pkg::OP_SETSC, 1'($urandom), 24'($urandom), 1'($urandom),
           24'($urandom), ($urandom_range(5) == 0) ? 52'sd0 : rand_scale());
    end else begin
      send(lcts_pkg::op_t'($urandom_range(3)), 1'($urandom), 24'($urandom), 1'($urandom),
           24'($urandom), rand_scale());
    end
  endtask

  initial begin
    int phase_idle[4][2];
    logic [15:0] deadbands[4];
    phase_idle = '{'{0, 0}, '{77, 0}, '{0, 77}, '{35, 35}};
    deadbands = '{16'd0, 16'd65535, 16'd200, 16'd7};
    board.init();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed requests
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'h7FFFFF, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'h800000, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_MEASURE, 1'b0, 24'h123456, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_TARE, 1'b1, 24'h000000, 1'b1, 24'd0, 52'sd0);
    send(lcts_pkg::OP_TARE, 1'b1, 24'h001000, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_TARE, 1'b1, 24'h000000, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_TARE, 1'b0, 24'hFFFFFF, 1'b1, 24'd0, 52'sd0);
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'h020000, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_CAL, 1'b1, 24'h040000, 1'b0, 24'hFFFFFF, 52'sd0);
    send(lcts_pkg::OP_CAL, 1'b1, 24'h040000, 1'b1, 24'd0, 52'sd0);
    send(lcts_pkg::OP_TARE, 1'b1, 24'h050000, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_CAL, 1'b1, 24'h060000, 1'b1, 24'd1000, 52'sd0);
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'h070000, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_CAL, 1'b1, 24'h001000, 1'b1, 24'd1, 52'sd0);
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'hFFFFFF, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_SETSC, 1'b1, 24'd0, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_SETSC, 1'b1, 24'd0, 1'b0, 24'd0, 52'sh7FFFFFFFFFFFF);
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'h800000, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_SETSC, 1'b1, 24'd0, 1'b0, 24'd0, 52'sh8000000000000);
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'h7FFFFF, 1'b0, 24'd0, 52'sd0);
    // zero scale via calibrate with zero net
    send(lcts_pkg::OP_TARE, 1'b1, 24'h000100, 1'b1, 24'd0, 52'sd0);
    send(lcts_pkg::OP_CAL, 1'b1, 24'h000100, 1'b1, 24'd500, 52'sd0);
    send(lcts_pkg::OP_MEASURE, 1'b1, 24'h000300, 1'b0, 24'd0, 52'sd0);
    send(lcts_pkg::OP_SETSC, 1'b1, 24'd0, 1'b0, 24'd0, 52'sd27525120);
    // full batch saturation
    for (int i = 0; i < 260; i++)
      send(lcts_pkg::OP_TARE, 1'b1, 24'($urandom_range(1000, 1)), i == 259, 24'd0, 52'sd0);
    // hold off until everything has drained
    drain();

    for (int p = 0; p < 4; p++) begin
      write_deadband(deadbands[p]);
      send_idle = phase_idle[p][0];
      recv_idle = phase_idle[p][1];
      for (int i = 0; i < 25; i++) random_request();
    end
    send_idle = 0;
    recv_idle = 0;
    drain();
    if (err_count == 0 && board.pending.size() == 0) begin
      $display("load_cell_tare_and_scale_tb passed");
    end else begin
      $display("load_cell_tare_and_scale_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/lcts_pkg.sv
design/lcts_front.sv
design/lcts_div.sv
design/lcts_back.sv
design/load_cell_tare_and_scale.sv
verif/load_cell_tare_and_scale_tb.sv
